// ----- hdl/can_busoff_recovery_manager_defines.svh -----
// assertion macros for the can bus-off recovery manager
`ifndef CAN_BUSOFF_RECOVERY_MANAGER_DEFINES_SVH
`define CAN_BUSOFF_RECOVERY_MANAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define CBRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent at one edge implies consequent at the next edge
`define CBRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CBRM_ASSERT(lbl, prop, msg)
`define CBRM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/cbrm_pkg.sv -----
// shared types, constants and codes for the can bus-off recovery manager
package cbrm_pkg;

    // number of controller ports handled
    localparam int PORT_COUNT = 4;

    // field widths
    localparam int OP_W    = 2;
    localparam int PORT_W  = 2;
    localparam int VAL_W   = 16;
    localparam int MASK_W  = 4;

    // opcodes
    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_BUSOFF    = 2'd1;
    localparam logic [OP_W-1:0] OP_RECOVERED = 2'd2;
    localparam logic [OP_W-1:0] OP_SLEEP     = 2'd3;

    // register indexes on the apb port
    localparam logic [1:0] REG_FAST_PERIOD = 2'd0;
    localparam logic [1:0] REG_SLOW_PERIOD = 2'd1;
    localparam logic [1:0] REG_FAST_LIMIT  = 2'd2;

    // register reset values
    localparam logic [VAL_W-1:0] FAST_PERIOD_RST = 16'd100;
    localparam logic [VAL_W-1:0] SLOW_PERIOD_RST = 16'd1000;
    localparam logic [VAL_W-1:0] FAST_LIMIT_RST  = 16'd3;

    // configuration seen by every port
    typedef struct packed {
        logic [VAL_W-1:0] fast_period;
        logic [VAL_W-1:0] slow_period;
        logic [VAL_W-1:0] fast_limit;
    } cbrm_cfg_t;

    // per-port command for one transaction
    typedef struct packed {
        logic            step;
        logic [OP_W-1:0] op;
        logic            sel;
        logic            mainpower;
        logic            acc;
    } cbrm_port_cmd_t;

    // per-port status after the transaction
    typedef struct packed {
        logic             reinit;
        logic             recovering;
        logic [VAL_W-1:0] attempts;
    } cbrm_port_stat_t;

    // true when the port number addresses an existing port
    function automatic logic port_valid(input logic [PORT_W-1:0] p);
        return int'(p) < PORT_COUNT;
    endfunction

endpackage

// ----- hdl/cbrm_cfg.sv -----
// apb register file holding the recovery periods and the fast attempt limit
module cbrm_cfg
    import cbrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cbrm_cfg_t   cfg
);

    logic [VAL_W-1:0] fast_period_reg;
    logic [VAL_W-1:0] slow_period_reg;
    logic [VAL_W-1:0] fast_limit_reg;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_period_reg <= FAST_PERIOD_RST;
            slow_period_reg <= SLOW_PERIOD_RST;
            fast_limit_reg  <= FAST_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FAST_PERIOD: fast_period_reg <= pwdata[VAL_W-1:0];
                REG_SLOW_PERIOD: slow_period_reg <= pwdata[VAL_W-1:0];
                REG_FAST_LIMIT:  fast_limit_reg  <= pwdata[VAL_W-1:0];
                default:         ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_FAST_PERIOD: prdata = {16'd0, fast_period_reg};
            REG_SLOW_PERIOD: prdata = {16'd0, slow_period_reg};
            REG_FAST_LIMIT:  prdata = {16'd0, fast_limit_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.fast_period = fast_period_reg;
    assign cfg.slow_period = slow_period_reg;
    assign cfg.fast_limit  = fast_limit_reg;

endmodule

// ----- hdl/cbrm_port.sv -----
// state and update logic of one controller port
module cbrm_port
    import cbrm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cbrm_cfg_t       cfg,
    input  cbrm_port_cmd_t  cmd,
    output cbrm_port_stat_t stat
);

    logic [VAL_W-1:0] att_reg,  att_next;
    logic [VAL_W-1:0] cd_reg,   cd_next;
    logic             run_reg,  run_next;
    logic             rec_reg,  rec_next;
    logic             reinit;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] cd_dec;

    // reload value from the attempt count, a zero period acts as one
    always_comb
    begin
        period = (att_reg < cfg.fast_limit) ? cfg.fast_period : cfg.slow_period;
        if (period == '0)
            period = VAL_W'(1);
    end

    assign cd_dec = (cd_reg != '0) ? cd_reg - VAL_W'(1) : cd_reg;

    // next state for this transaction
    always_comb
    begin
        att_next = att_reg;
        cd_next  = cd_reg;
        run_next = run_reg;
        rec_next = rec_reg;
        reinit   = 1'b0;
        unique case (cmd.op)
            OP_TICK:
            begin
                if (run_reg)
                begin
                    cd_next = cd_dec;
                    if (cd_dec == '0)
                    begin
                        run_next = 1'b0;
                        if (rec_reg)
                        begin
                            if (cmd.mainpower && cmd.acc)
                                reinit = 1'b1;
                            else
                            begin
                                cd_next  = period;
                                run_next = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_BUSOFF:
            begin
                if (cmd.sel)
                begin
                    rec_next = 1'b1;
                    cd_next  = period;
                    run_next = 1'b1;
                    if (att_reg != '1)
                        att_next = att_reg + VAL_W'(1);
                end
            end
            OP_RECOVERED:
            begin
                if (cmd.sel && rec_reg)
                begin
                    att_next = '0;
                    cd_next  = '0;
                    run_next = 1'b0;
                    rec_next = 1'b0;
                end
            end
            OP_SLEEP:
            begin
                att_next = '0;
                cd_next  = '0;
                run_next = 1'b0;
                rec_next = 1'b0;
            end
            default: ;
        endcase
    end

    // state registers, updated when the transaction leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_reg <= '0;
            cd_reg  <= '0;
            run_reg <= 1'b0;
            rec_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            att_reg <= att_next;
            cd_reg  <= cd_next;
            run_reg <= run_next;
            rec_reg <= rec_next;
        end
    end

    assign stat.reinit     = reinit;
    assign stat.recovering = rec_next;
    assign stat.attempts   = att_next;

endmodule

// ----- hdl/can_busoff_recovery_manager.sv -----
// top level of the can bus-off recovery manager
//
// channel   direction  bits used        contents
// s_axis    in         tdata[5:0]       opcode, port, mainpower_active, acc_active
// m_axis    out        tdata[24:0]      reinit_mask, deinit_request, recovering_mask,
//                                       attempt_count
// apb       in/out     paddr[3:2]       fast period, slow period, fast attempt limit
//
// an accepted transaction is held in the input register until it can advance, then the port
// update logic writes the port state and the result register in the same cycle
// throughput is one transaction per cycle while the output is not stalled
// rst_n clears all port state and both valid flags; registers return to their defaults
// a stalled output holds the result; the input stage keeps accepting while the result
// register is free or is being emptied in the same cycle
`include "can_busoff_recovery_manager_defines.svh"

module can_busoff_recovery_manager
    import cbrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // opcode[1:0], port[3:2], mainpower_active[4],
                                        // acc_active[5], zero[7:6]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // reinit_mask[3:0], deinit_request[4],
                                        // recovering_mask[8:5], attempt_count[24:9],
                                        // zero[31:25]
);

    cbrm_cfg_t        cfg;
    cbrm_port_cmd_t   cmd  [PORT_COUNT];
    cbrm_port_stat_t  stat [PORT_COUNT];

    logic              in_valid_reg;
    logic [OP_W-1:0]   in_op_reg;
    logic [PORT_W-1:0] in_port_reg;
    logic              in_mainp_reg;
    logic              in_acc_reg;

    logic              out_valid_reg;
    logic [MASK_W-1:0] reinit_reg;
    logic              deinit_reg;
    logic [MASK_W-1:0] recmask_reg;
    logic [VAL_W-1:0]  attcnt_reg;

    logic              advance;
    logic              in_take;
    logic              item_valid;
    logic [MASK_W-1:0] reinit_vec;
    logic [MASK_W-1:0] rec_vec;
    logic [VAL_W-1:0]  att_sel;
    logic              deinit;

    // configuration registers
    cbrm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline handshake
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg    <= s_axis_tdata[1:0];
            in_port_reg  <= s_axis_tdata[3:2];
            in_mainp_reg <= s_axis_tdata[4];
            in_acc_reg   <= s_axis_tdata[5];
        end
    end

    assign item_valid = port_valid(in_port_reg);

    // one state cell per port
    for (genvar p = 0; p < PORT_COUNT; p++)
    begin : g_port
        assign cmd[p].step      = advance;
        assign cmd[p].op        = in_op_reg;
        assign cmd[p].sel       = item_valid && (int'(in_port_reg) == p);
        assign cmd[p].mainpower = in_mainp_reg;
        assign cmd[p].acc       = in_acc_reg;

        cbrm_port u_port (
            .clk   (clk),
            .rst_n (rst_n),
            .cfg   (cfg),
            .cmd   (cmd[p]),
            .stat  (stat[p])
        );
    end

    // masks only carry the first four ports
    for (genvar b = 0; b < MASK_W; b++)
    begin : g_mask
        if (b < PORT_COUNT)
        begin : g_on
            assign reinit_vec[b] = stat[b].reinit;
            assign rec_vec[b]    = stat[b].recovering;
        end
        else
        begin : g_off
            assign reinit_vec[b] = 1'b0;
            assign rec_vec[b]    = 1'b0;
        end
    end

    // attempt count of the addressed port
    always_comb
    begin
        att_sel = '0;
        for (int p = 0; p < PORT_COUNT; p++)
            if (cmd[p].sel)
                att_sel = stat[p].attempts;
    end

    assign deinit = (in_op_reg == OP_BUSOFF) && item_valid && in_mainp_reg;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            reinit_reg  <= reinit_vec;
            deinit_reg  <= deinit;
            recmask_reg <= rec_vec;
            attcnt_reg  <= att_sel;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, attcnt_reg, recmask_reg, deinit_reg, reinit_reg};

    // checks
    `CBRM_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance, in_valid_reg,
        "input transaction dropped while waiting")
    `CBRM_ASSERT_NEXT(a_adv_out, advance, out_valid_reg,
        "result register not loaded after advance")
    `CBRM_ASSERT(a_reinit_rec, !out_valid_reg || ((reinit_reg & ~recmask_reg) == '0),
        "reinit reported on a port that is not recovering")
    `CBRM_ASSERT(a_deinit_excl, !out_valid_reg || !(deinit_reg && (reinit_reg != '0)),
        "deinit and reinit reported by the same transaction")

endmodule

// ----- tb/tb_can_busoff_recovery_manager.sv -----
// self-checking testbench for the can bus-off recovery manager
module tb_can_busoff_recovery_manager
    import cbrm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 500000;

    // one result transaction, last field in the lowest bits
    typedef struct packed {
        logic [VAL_W-1:0]  attempts;
        logic [MASK_W-1:0] recovering;
        logic              deinit;
        logic [MASK_W-1:0] reinit;
    } busoff_status_t;

    // per-port recovery state mirror and queue of predicted status words
    class busoff_scoreboard;
        logic [VAL_W-1:0] fast_period;
        logic [VAL_W-1:0] slow_period;
        logic [VAL_W-1:0] fast_limit;
        logic [VAL_W-1:0] attempts [PORT_COUNT];
        logic [VAL_W-1:0] countdown [PORT_COUNT];
        bit               recovering [PORT_COUNT];
        bit               running [PORT_COUNT];
        busoff_status_t   status_q [$];
        int               errors;

        function new();
            fast_period = FAST_PERIOD_RST;
            slow_period = SLOW_PERIOD_RST;
            fast_limit  = FAST_LIMIT_RST;
            for (int p = 0; p < PORT_COUNT; p++)
                clear_port(p);
            errors = 0;
        endfunction

        function void clear_port(int p);
            attempts[p]   = '0;
            recovering[p] = 1'b0;
            countdown[p]  = '0;
            running[p]    = 1'b0;
        endfunction

        // fast period while below the attempt limit, a zero period acts as one
        function void load_countdown(int p);
            logic [VAL_W-1:0] per;
            per = (attempts[p] < fast_limit) ? fast_period : slow_period;
            if (per == '0)
                per = VAL_W'(1);
            countdown[p] = per;
            running[p]   = 1'b1;
        endfunction

        function void set_config(logic [1:0] idx, logic [VAL_W-1:0] value);
            case (idx)
                REG_FAST_PERIOD: fast_period = value;
                REG_SLOW_PERIOD: slow_period = value;
                REG_FAST_LIMIT:  fast_limit  = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // apply one accepted event and queue the status it should produce
        function void note_event(logic [7:0] item);
            logic [OP_W-1:0]   op;
            logic [PORT_W-1:0] port;
            logic              mainpower;
            logic              acc;
            bit                valid;
            busoff_status_t    st;
            op        = item[1:0];
            port      = item[3:2];
            mainpower = item[4];
            acc       = item[5];
            valid     = int'(port) < PORT_COUNT;
            st        = '0;
            case (op)
                OP_TICK:
                    for (int p = 0; p < PORT_COUNT; p++)
                    begin
                        if (running[p])
                        begin
                            if (countdown[p] != '0)
                                countdown[p] = countdown[p] - 1'b1;
                            if (countdown[p] == '0)
                            begin
                                running[p] = 1'b0;
                                // expiry only matters on a recovering port
                                if (recovering[p])
                                begin
                                    if (mainpower && acc)
                                    begin
                                        if (p < MASK_W)
                                            st.reinit[p] = 1'b1;
                                    end
                                    else
                                        load_countdown(p);
                                end
                            end
                        end
                    end
                OP_BUSOFF:
                    if (valid)
                    begin
                        st.deinit = mainpower;
                        recovering[port] = 1'b1;
                        load_countdown(port);
                        if (attempts[port] != '1)
                            attempts[port] = attempts[port] + 1'b1;
                    end
                OP_RECOVERED:
                    if (valid && recovering[port])
                        clear_port(port);
                default:
                    for (int p = 0; p < PORT_COUNT; p++)
                        clear_port(p);
            endcase
            for (int p = 0; p < PORT_COUNT && p < MASK_W; p++)
                st.recovering[p] = recovering[p];
            st.attempts = valid ? attempts[port] : '0;
            status_q.push_back(st);
        endfunction

        task report_mismatch(string what, int unsigned want, int unsigned got);
            $display("%0t ERROR %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
            errors++;
        endtask

        // compare one result transaction with the oldest prediction
        task check_status(logic [31:0] tdata);
            busoff_status_t want;
            busoff_status_t got;
            got = tdata[24:0];
            if (status_q.size() == 0)
            begin
                report_mismatch("result with nothing pending", 0, tdata);
                return;
            end
            want = status_q.pop_front();
            if (got.reinit != want.reinit)
                report_mismatch("reinit_mask", 32'(want.reinit), 32'(got.reinit));
            if (got.deinit != want.deinit)
                report_mismatch("deinit_request", 32'(want.deinit), 32'(got.deinit));
            if (got.recovering != want.recovering)
                report_mismatch("recovering_mask", 32'(want.recovering),
                                32'(got.recovering));
            if (got.attempts != want.attempts)
                report_mismatch("attempt_count", 32'(want.attempts), 32'(got.attempts));
            if (tdata[31:25] != '0)
                report_mismatch("tdata pad bits", 0, 32'(tdata[31:25]));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // opcode[1:0], port[3:2], mainpower_active[4],
                                 // acc_active[5], zero[7:6]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // reinit_mask[3:0], deinit_request[4],
                                 // recovering_mask[8:5], attempt_count[24:9], zero[31:25]

    busoff_scoreboard sb = new();
    bit               idle_on;
    int               tx_calm;
    int               rx_calm;
    int unsigned      cycle_count;

    can_busoff_recovery_manager uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(m_axis_tdata);
    end

    // idle cycles before a transaction, with occasional stretches of none
    function automatic int draw_gap(inout int calm_left);
        if (!idle_on)
            return 0;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(5, 30);
        return $urandom_range(0, 13);
    endfunction

    // one input transaction, entered and left at a falling edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic [PORT_W-1:0] port,
                             input logic mainpower, input logic acc);
        int         gap;
        logic [7:0] item;
        item = {2'b00, acc, mainpower, port, op};
        gap  = draw_gap(tx_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_event(item);
        @(negedge clk);
    endtask

    // setup and access phase of one apb transaction
    task automatic apb_access(input logic [1:0] idx, input logic write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write a register, then read it back
    task automatic write_register(input logic [1:0] idx, input logic [VAL_W-1:0] value);
        logic [31:0] rdata;
        apb_access(idx, 1'b1, {16'h0000, value}, rdata);
        sb.set_config(idx, value);
        apb_access(idx, 1'b0, '0, rdata);
        if (rdata[VAL_W-1:0] != value)
            sb.report_mismatch("register readback", 32'(value), 32'(rdata[VAL_W-1:0]));
    endtask

    // stop sending and let every pending result drain
    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input logic [VAL_W-1:0] fast, input logic [VAL_W-1:0] slow,
                             input logic [VAL_W-1:0] limit);
        go_idle();
        write_register(REG_FAST_PERIOD, fast);
        write_register(REG_SLOW_PERIOD, slow);
        write_register(REG_FAST_LIMIT, limit);
    endtask

    // random events, weighted toward ticks so countdowns expire
    task automatic run_phase(input int count, input logic [VAL_W-1:0] fast,
                             input logic [VAL_W-1:0] slow, input logic [VAL_W-1:0] limit);
        int                pick;
        logic [OP_W-1:0]   op;
        logic [PORT_W-1:0] port;
        configure(fast, slow, limit);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                op = OP_TICK;
            else if (pick < 80)
                op = OP_BUSOFF;
            else if (pick < 96)
                op = OP_RECOVERED;
            else
                op = OP_SLEEP;
            port = PORT_W'($urandom_range(0, PORT_COUNT - 1));
            send_item(op, port, $urandom_range(0, 4) != 0, $urandom_range(0, 3) != 0);
        end
    endtask

    // result side stalls
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(rx_calm);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_on       = 1'b1;
        tx_calm       = 0;
        rx_calm       = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: idle tick, recovered on an idle port, bus-off with and without power, recovery, sleep
        send_item(OP_TICK, 2'd0, 1'b1, 1'b1);
        send_item(OP_RECOVERED, 2'd1, 1'b1, 1'b1);
        send_item(OP_BUSOFF, 2'd0, 1'b0, 1'b1);
        send_item(OP_BUSOFF, 2'd3, 1'b1, 1'b0);
        send_item(OP_RECOVERED, 2'd3, 1'b1, 1'b1);
        send_item(OP_SLEEP, 2'd0, 1'b1, 1'b1);

        // fast expiry with power, then slow period with reload on missing power
        configure(16'd2, 16'd3, 16'd1);
        send_item(OP_BUSOFF, 2'd2, 1'b1, 1'b1);
        send_item(OP_TICK, 2'd0, 1'b1, 1'b1);
        send_item(OP_TICK, 2'd1, 1'b1, 1'b1);
        send_item(OP_BUSOFF, 2'd2, 1'b1, 1'b0);
        send_item(OP_TICK, 2'd2, 1'b0, 1'b1);
        send_item(OP_TICK, 2'd3, 1'b1, 1'b0);
        send_item(OP_TICK, 2'd0, 1'b0, 1'b0);
        repeat (3) send_item(OP_TICK, 2'd2, 1'b1, 1'b1);
        send_item(OP_BUSOFF, 2'd1, 1'b0, 1'b0);
        send_item(OP_RECOVERED, 2'd1, 1'b0, 1'b0);
        send_item(OP_BUSOFF, 2'd0, 1'b1, 1'b1);
        send_item(OP_SLEEP, 2'd3, 1'b0, 1'b0);

        // zero period registers behave as one tick
        configure(16'd0, 16'd0, 16'd0);
        send_item(OP_BUSOFF, 2'd3, 1'b1, 1'b1);
        send_item(OP_TICK, 2'd3, 1'b1, 1'b1);
        send_item(OP_BUSOFF, 2'd3, 1'b1, 1'b1);
        send_item(OP_TICK, 2'd1, 1'b1, 1'b0);

        // random phases over several settings, extremes included
        run_phase(50, 16'd1, 16'd1, 16'd0);
        run_phase(50, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (4)
            run_phase(100, VAL_W'($urandom_range(1, 6)), VAL_W'($urandom_range(1, 12)),
                      VAL_W'($urandom_range(0, 4)));
        run_phase(50, 16'd0, 16'd2, 16'd1);

        // back to back bus-off events on one port at full rate
        configure(16'd3, 16'd5, 16'hFFFF);
        idle_on = 1'b0;
        repeat (40)
            send_item(OP_BUSOFF, 2'd1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        idle_on = 1'b1;
        repeat (8)
            send_item(OP_TICK, 2'd1, 1'b1, 1'($urandom_range(0, 1)));
        send_item(OP_RECOVERED, 2'd1, 1'b1, 1'b1);

        run_phase(30, VAL_W'($urandom_range(1, 4)), VAL_W'($urandom_range(1, 8)),
                  VAL_W'($urandom_range(0, 3)));

        go_idle();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
